@@ rtl/spq_pkg.sv @@
package spq_pkg;

  typedef struct packed {
    logic [4:0]  prio;
    logic [63:0] name_hi;
    logic [63:0] name_mid;
    logic [63:0] name_lo;
    logic [7:0]  reg_hi;
    logic [63:0] reg_lo;
  } entry_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADPRIO = 2'd3;

  localparam logic [4:0] PRIO_MIN     = 5'd1;
  localparam logic [4:0] PRIO_MAX     = 5'd20;
  localparam logic [4:0] THRESH_RESET = 5'd10;

  localparam int MAX_RESULTS = 32;

endpackage

@@ rtl/spq_if.sv @@
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  priority_req;
  logic [63:0] name_word_hi;
  logic [63:0] name_word_mid;
  logic [63:0] name_word_lo;
  logic [7:0]  reg_word_hi;
  logic [63:0] reg_word_lo;

  modport source (
    output valid, cmd, priority_req, name_word_hi, name_word_mid, name_word_lo,
           reg_word_hi, reg_word_lo,
    input  ready
  );
  modport sink (
    input  valid, cmd, priority_req, name_word_hi, name_word_mid, name_word_lo,
           reg_word_hi, reg_word_lo,
    output ready
  );
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  out_priority;
  logic [63:0] out_name_hi;
  logic [63:0] out_name_mid;
  logic [63:0] out_name_lo;
  logic [7:0]  out_reg_hi;
  logic [63:0] out_reg_lo;
  logic        high_class;
  logic        last;

  modport source (
    output valid, status, out_priority, out_name_hi, out_name_mid, out_name_lo,
           out_reg_hi, out_reg_lo, high_class, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_priority, out_name_hi, out_name_mid, out_name_lo,
           out_reg_hi, out_reg_lo, high_class, last,
    output ready
  );
endinterface

@@ rtl/spq_store.sv @@
module spq_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  spq_pkg::entry_t    wdata,
  input  logic [AW-1:0]      raddr,
  output spq_pkg::entry_t    rdata
);

  spq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/spq_ctrl.sv @@
module spq_ctrl #(
  parameter int CAPACITY = 32,
  parameter int IW       = 5,
  parameter int CW       = 6
) (
  input  logic            clk,
  input  logic            rst,
  spq_req_if.sink         req,
  spq_rsp_if.source       rsp,
  input  logic [4:0]      threshold,
  output logic            mem_we,
  output logic [IW-1:0]   mem_waddr,
  output spq_pkg::entry_t mem_wdata,
  output logic [IW-1:0]   mem_raddr,
  input  spq_pkg::entry_t mem_rdata
);

  localparam int LIM_MAX = (CAPACITY < spq_pkg::MAX_RESULTS) ? CAPACITY
                                                             : spq_pkg::MAX_RESULTS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_INS   = 4'd2;
  localparam logic [3:0] S_PUT0  = 4'd3;
  localparam logic [3:0] S_NEW   = 4'd4;
  localparam logic [3:0] S_ERR   = 4'd5;
  localparam logic [3:0] S_FRONT = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_LIST  = 4'd8;

  logic [3:0]      state, state_next;
  logic [1:0]      cmd;
  spq_pkg::entry_t new_e;
  logic [CW-1:0]   count, count_next;
  logic [IW-1:0]   cur, cur_next;
  logic [1:0]      err_code, err_code_next;

  logic            out_valid;
  spq_pkg::entry_t out_e;
  logic [1:0]      out_status;
  logic            out_high;
  logic            out_last;

  logic            out_free;
  logic            load;
  spq_pkg::entry_t load_e;
  logic [1:0]      load_status;
  logic            load_high;
  logic            load_last;
  logic [CW-1:0]   lim;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign lim = (count > CW'(LIM_MAX)) ? CW'(LIM_MAX) : count;

  always_comb begin
    state_next    = state;
    count_next    = count;
    cur_next      = cur;
    err_code_next = err_code;
    mem_we        = 1'b0;
    mem_waddr     = cur;
    mem_wdata     = new_e;
    mem_raddr     = cur;
    load          = 1'b0;
    load_e        = mem_rdata;
    load_status   = spq_pkg::ST_OK;
    load_high     = 1'b0;
    load_last     = 1'b1;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (cmd == spq_pkg::CMD_INSERT) begin
          if (new_e.prio < spq_pkg::PRIO_MIN || new_e.prio > spq_pkg::PRIO_MAX) begin
            err_code_next = spq_pkg::ST_BADPRIO;
            state_next    = S_ERR;
          end else if (count == CW'(CAPACITY)) begin
            err_code_next = spq_pkg::ST_FULL;
            state_next    = S_ERR;
          end else if (count == '0) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            count_next = count + 1'b1;
            state_next = S_NEW;
          end else begin
            // Walk down from the tail, moving larger entries up by one.
            cur_next   = IW'(count - 1'b1);
            mem_raddr  = IW'(count - 1'b1);
            state_next = S_INS;
          end
        end else if (count == '0) begin
          err_code_next = spq_pkg::ST_EMPTY;
          state_next    = S_ERR;
        end else begin
          cur_next   = '0;
          mem_raddr  = '0;
          state_next = (cmd == spq_pkg::CMD_LIST) ? S_LIST : S_FRONT;
        end
      end
      S_INS: begin
        if (mem_rdata.prio > new_e.prio) begin
          mem_we    = 1'b1;
          mem_waddr = cur + 1'b1;
          mem_wdata = mem_rdata;
          if (cur == '0) begin
            state_next = S_PUT0;
          end else begin
            cur_next  = cur - 1'b1;
            mem_raddr = cur - 1'b1;
          end
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = cur + 1'b1;
          count_next = count + 1'b1;
          state_next = S_NEW;
        end
      end
      S_PUT0: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        count_next = count + 1'b1;
        state_next = S_NEW;
      end
      S_NEW: begin
        load_e    = new_e;
        load_high = new_e.prio < threshold;
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        load_e      = '0;
        load_status = err_code;
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FRONT: begin
        mem_raddr = '0;
        load_high = mem_rdata.prio < threshold;
        if (out_free) begin
          load = 1'b1;
          if (cmd == spq_pkg::CMD_REMOVE && count != CW'(1)) begin
            cur_next   = '0;
            mem_raddr  = IW'(1);
            state_next = S_SHIFT;
          end else begin
            if (cmd == spq_pkg::CMD_REMOVE) begin
              count_next = '0;
            end
            state_next = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        // Read data holds the entry one above cur; move it down.
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = mem_rdata;
        if (CW'(cur) + CW'(2) == count) begin
          count_next = count - 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_next  = cur + 1'b1;
          mem_raddr = cur + IW'(2);
        end
      end
      S_LIST: begin
        load_high = mem_rdata.prio < threshold;
        load_last = (CW'(cur) + CW'(1) == lim);
        if (out_free) begin
          load = 1'b1;
          if (load_last) begin
            state_next = S_IDLE;
          end else begin
            cur_next  = cur + 1'b1;
            mem_raddr = cur + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur       <= '0;
      err_code  <= spq_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cur      <= cur_next;
      err_code <= err_code_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd            <= req.cmd;
      new_e.prio     <= req.priority_req;
      new_e.name_hi  <= req.name_word_hi;
      new_e.name_mid <= req.name_word_mid;
      new_e.name_lo  <= req.name_word_lo;
      new_e.reg_hi   <= req.reg_word_hi;
      new_e.reg_lo   <= req.reg_word_lo;
    end
    if (load) begin
      out_e      <= load_e;
      out_status <= load_status;
      out_high   <= load_high;
      out_last   <= load_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_priority = out_e.prio;
  assign rsp.out_name_hi  = out_e.name_hi;
  assign rsp.out_name_mid = out_e.name_mid;
  assign rsp.out_name_lo  = out_e.name_lo;
  assign rsp.out_reg_hi   = out_e.reg_hi;
  assign rsp.out_reg_lo   = out_e.reg_lo;
  assign rsp.high_class   = out_high;
  assign rsp.last         = out_last;

endmodule

@@ rtl/stable_priority_queue.sv @@
// Channel  Direction  Handshake      Carries
// req      in         valid/ready    cmd, priority_req, name and registration words
// rsp      out        valid/ready    status, reported entry, high_class, last
// apb      in         psel/penable   split_threshold at byte address 0
//
// The entries sit in one memory with a registered read port, kept sorted; a sequencer
// walks it one entry per cycle while the output is free. The block takes no item until
// the previous one has been fully handled.
// Output stalls hold the sequencer in place. Reset empties the queue at once.
module stable_priority_queue #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  spq_req_if.sink     req,
  spq_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [4:0]      threshold;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [IW-1:0]   mem_raddr;
  spq_pkg::entry_t mem_wdata;
  spq_pkg::entry_t mem_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= spq_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      threshold <= pwdata[4:0];
    end
  end

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .threshold (threshold),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  spq_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ tb/stable_priority_queue_test.sv @@
module stable_priority_queue_test;

  localparam int CAPACITY = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 22;
  localparam logic [2:0] ADDR_SPLIT_THRESHOLD = 3'd0;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

  typedef struct packed {
    logic [1:0]      cmd;
    spq_pkg::entry_t rec;
  } command_t;

  typedef struct packed {
    logic [1:0]      status;
    spq_pkg::entry_t rec;
    logic            high_class;
    logic            last;
  } report_t;

  // One row of the directed plan. Rows with reps above one repeat the command;
  // repeated inserts draw a random legal priority.
  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] prio;
    fill_t      fill;
    logic [5:0] reps;
    logic       typed;
    logic [1:0] status;
  } plan_row_t;

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{spq_pkg::CMD_REMOVE, 5'd0,  FILL_ZERO, 6'd1,  1'b1, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_PEEK,   5'd0,  FILL_ZERO, 6'd1,  1'b1, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_LIST,   5'd0,  FILL_ZERO, 6'd1,  1'b1, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_INSERT, 5'd0,  FILL_ZERO, 6'd1,  1'b1, spq_pkg::ST_BADPRIO},
    '{spq_pkg::CMD_INSERT, 5'd21, FILL_ONES, 6'd1,  1'b1, spq_pkg::ST_BADPRIO},
    '{spq_pkg::CMD_INSERT, 5'd31, FILL_RAND, 6'd1,  1'b1, spq_pkg::ST_BADPRIO},
    '{spq_pkg::CMD_INSERT, 5'd20, FILL_ONES, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd1,  FILL_ZERO, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd10, FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd10, FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd9,  FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd20, FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_PEEK,   5'd0,  FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_LIST,   5'd0,  FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_REMOVE, 5'd0,  FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd0,  FILL_RAND, 6'd27, 1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_INSERT, 5'd5,  FILL_RAND, 6'd1,  1'b1, spq_pkg::ST_FULL},
    '{spq_pkg::CMD_INSERT, 5'd0,  FILL_ONES, 6'd1,  1'b1, spq_pkg::ST_BADPRIO},
    '{spq_pkg::CMD_INSERT, 5'd25, FILL_RAND, 6'd1,  1'b1, spq_pkg::ST_BADPRIO},
    '{spq_pkg::CMD_LIST,   5'd0,  FILL_RAND, 6'd1,  1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_REMOVE, 5'd0,  FILL_RAND, 6'd32, 1'b0, spq_pkg::ST_OK},
    '{spq_pkg::CMD_REMOVE, 5'd0,  FILL_RAND, 6'd1,  1'b1, spq_pkg::ST_EMPTY},
    '{spq_pkg::CMD_LIST,   5'd0,  FILL_RAND, 6'd1,  1'b1, spq_pkg::ST_EMPTY}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_priority_queue #(.CAPACITY(CAPACITY)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted contents of the ordered store and the reports still owed.
  spq_pkg::entry_t shelf[$];
  report_t         pending_reports[$];
  logic [4:0]      split_thr;

  int mismatch_count;
  int cycle_count;
  int hold_requests;
  int hold_served;
  int hold_left;
  bit idle_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic report_t error_report(input logic [1:0] code);
    report_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic report_t entry_report(input spq_pkg::entry_t e, input bit is_last);
    report_t r;
    r.status = spq_pkg::ST_OK;
    r.rec = e;
    r.high_class = (e.prio < split_thr);
    r.last = is_last;
    return r;
  endfunction

  function automatic string describe(input report_t r);
    return $sformatf("st=%0d pr=%0d hc=%0d last=%0d name=%h_%h_%h reg=%h_%h",
                     r.status, r.rec.prio, r.high_class, r.last, r.rec.name_hi,
                     r.rec.name_mid, r.rec.name_lo, r.rec.reg_hi, r.rec.reg_lo);
  endfunction

  function automatic spq_pkg::entry_t make_record(input logic [4:0] prio,
                                                  input fill_t fill);
    spq_pkg::entry_t r;
    case (fill)
      FILL_ZERO: r = '0;
      FILL_ONES: r = '1;
      default: begin
        r.name_hi = {$urandom, $urandom};
        r.name_mid = {$urandom, $urandom};
        r.name_lo = {$urandom, $urandom};
        r.reg_hi = 8'($urandom);
        r.reg_lo = {$urandom, $urandom};
      end
    endcase
    r.prio = prio;
    return r;
  endfunction

  // Updates the predicted store for one command; publish queues the reports.
  function automatic void apply_command(input command_t c, input bit publish);
    report_t         out[$];
    spq_pkg::entry_t e;
    int              pos;
    int              cnt;
    if (c.cmd == spq_pkg::CMD_INSERT) begin
      if (c.rec.prio < spq_pkg::PRIO_MIN || c.rec.prio > spq_pkg::PRIO_MAX) begin
        out.push_back(error_report(spq_pkg::ST_BADPRIO));
      end else if (shelf.size() >= CAPACITY) begin
        out.push_back(error_report(spq_pkg::ST_FULL));
      end else begin
        pos = 0;
        while (pos < shelf.size() && shelf[pos].prio <= c.rec.prio) pos++;
        shelf.push_back(c.rec);
        for (int i = shelf.size() - 1; i > pos; i--) shelf[i] = shelf[i - 1];
        shelf[pos] = c.rec;
        out.push_back(entry_report(c.rec, 1'b1));
      end
    end else if (shelf.size() == 0) begin
      out.push_back(error_report(spq_pkg::ST_EMPTY));
    end else if (c.cmd == spq_pkg::CMD_LIST) begin
      cnt = (shelf.size() > spq_pkg::MAX_RESULTS) ? spq_pkg::MAX_RESULTS : shelf.size();
      for (int i = 0; i < cnt; i++) out.push_back(entry_report(shelf[i], i == cnt - 1));
    end else begin
      out.push_back(entry_report(shelf[0], 1'b1));
      if (c.cmd == spq_pkg::CMD_REMOVE) e = shelf.pop_front();
    end
    if (publish) foreach (out[i]) pending_reports.push_back(out[i]);
  endfunction

  task automatic offer_command(input command_t c, input bit typed,
                               input logic [1:0] typed_status);
    while (idle_on && $urandom_range(99) < 27) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c.cmd;
    req_ch.priority_req <= c.rec.prio;
    req_ch.name_word_hi <= c.rec.name_hi;
    req_ch.name_word_mid <= c.rec.name_mid;
    req_ch.name_word_lo <= c.rec.name_lo;
    req_ch.reg_word_hi <= c.rec.reg_hi;
    req_ch.reg_word_lo <= c.rec.reg_lo;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (typed) begin
      apply_command(c, 1'b0);
      pending_reports.push_back(error_report(typed_status));
    end else begin
      apply_command(c, 1'b1);
    end
  endtask

  // A remove may still be shifting the store after its report has left.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SPLIT_THRESHOLD;
    pwdata <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    split_thr = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {27'd0, value}) begin
      if (mismatch_count < 10)
        $display("split_threshold readback: expected %0d, actual %0d", value, prdata);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stable_priority_queue_test: errors");
      $finish;
    end
  end

  // Result side: check every accepted item, then choose ready for the next cycle.
  always @(posedge clk) begin : result_side
    report_t got;
    report_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.rec.prio = rsp_ch.out_priority;
      got.rec.name_hi = rsp_ch.out_name_hi;
      got.rec.name_mid = rsp_ch.out_name_mid;
      got.rec.name_lo = rsp_ch.out_name_lo;
      got.rec.reg_hi = rsp_ch.out_reg_hi;
      got.rec.reg_lo = rsp_ch.out_reg_lo;
      got.high_class = rsp_ch.high_class;
      got.last = rsp_ch.last;
      if (pending_reports.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result: %s", describe(got));
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("result mismatch, expected %s", describe(want));
            $display("                 actual   %s", describe(got));
          end
          mismatch_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !rst && (!idle_on || $urandom_range(99) >= 27);
    end
  end

  initial begin : stimulus
    command_t   c;
    plan_row_t  row;
    int         pick;
    logic [4:0] thr;
    fill_t      fill;

    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = spq_pkg::CMD_INSERT;
    req_ch.priority_req = '0;
    req_ch.name_word_hi = '0;
    req_ch.name_word_mid = '0;
    req_ch.name_word_lo = '0;
    req_ch.reg_word_hi = '0;
    req_ch.reg_word_lo = '0;
    rsp_ch.ready = 1'b0;
    split_thr = spq_pkg::THRESH_RESET;
    mismatch_count = 0;
    cycle_count = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    idle_on = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the threshold still at its reset value.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      for (int k = 0; k < row.reps; k++) begin
        c.cmd = row.cmd;
        if (row.reps > 1 && row.cmd == spq_pkg::CMD_INSERT)
          c.rec = make_record(5'($urandom_range(spq_pkg::PRIO_MIN, spq_pkg::PRIO_MAX)),
                              row.fill);
        else
          c.rec = make_record(row.prio, row.fill);
        offer_command(c, row.typed, row.status);
      end
    end

    // Random part: each phase runs under its own threshold.
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: thr = 5'd1;
        1: thr = 5'd21;
        2: thr = 5'd0;
        3: thr = 5'd31;
        4: thr = spq_pkg::THRESH_RESET;
        default: thr = 5'($urandom_range(31));
      endcase
      write_threshold(thr);
      idle_on <= (phase != 0);
      // The long output hold stalls the block; the sender's next request waits until it is freed.
      if (phase == 2) hold_requests <= hold_requests + 1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(99);
        if (pick < 50) c.cmd = spq_pkg::CMD_INSERT;
        else if (pick < 75) c.cmd = spq_pkg::CMD_REMOVE;
        else if (pick < 88) c.cmd = spq_pkg::CMD_PEEK;
        else c.cmd = spq_pkg::CMD_LIST;
        pick = $urandom_range(9);
        fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
        pick = $urandom_range(99);
        if (pick < 3) c.rec = make_record(5'd0, fill);
        else if (pick < 10) c.rec = make_record(5'($urandom_range(21, 31)), fill);
        else if (pick < 40) c.rec = make_record(5'($urandom_range(1, 3)), fill);
        else
          c.rec = make_record(5'($urandom_range(spq_pkg::PRIO_MIN, spq_pkg::PRIO_MAX)),
                              fill);
        offer_command(c, 1'b0, spq_pkg::ST_OK);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("stable_priority_queue_test: clean");
    end else begin
      $display("stable_priority_queue_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_store.sv
rtl/spq_ctrl.sv
rtl/stable_priority_queue.sv
tb/stable_priority_queue_test.sv
